// ----- rtl/rsna_pkg.sv -----
// ----------------------------------------------------------------------------
// rsna_pkg
// Shared types, constants and string helpers for the station name assembler.
// ----------------------------------------------------------------------------
package rsna_pkg;

    localparam int NAME_LEN   = 8;
    localparam int CHAR_W     = 8;
    localparam int BLOCK_W    = 16;
    localparam int MIN_CHARS_W = 4;
    localparam int NAME_W     = NAME_LEN * CHAR_W;

    localparam logic [BLOCK_W-1:0]     GROUP_TYPE_MASK = 16'hF000;
    localparam logic [BLOCK_W-1:0]     BLOCK_A_CLEAR   = 16'h0000;
    localparam logic [1:0]             LAST_SEGMENT    = 2'd3;
    localparam logic [MIN_CHARS_W-1:0] MIN_CHARS_RESET = 4'd4;
    localparam logic [MIN_CHARS_W-1:0] MIN_CHARS_MAX   = 4'd8;

    typedef logic [CHAR_W-1:0] char_t;
    // entry k holds character k of the name
    typedef logic [NAME_LEN-1:0][CHAR_W-1:0] name_t;

    typedef struct packed {
        logic               rds_ready;
        logic [BLOCK_W-1:0] block_a;
        logic [BLOCK_W-1:0] block_b;
        logic [BLOCK_W-1:0] block_d;
    } poll_t;

    typedef struct packed {
        logic              name_valid;
        logic [NAME_W-1:0] station_name;
        logic              name_changed;
    } result_t;

    // equal up to and including the first zero byte of a
    function automatic logic cstr_equal(input name_t a, input name_t b);
        logic eq;
        logic done;
        eq   = 1'b1;
        done = 1'b0;
        for (int k = 0; k < NAME_LEN; k++)
        begin
            if (!done)
            begin
                if (a[k] != b[k])
                begin
                    eq   = 1'b0;
                    done = 1'b1;
                end
                else if (a[k] == '0)
                begin
                    done = 1'b1;
                end
            end
        end
        return eq;
    endfunction

    // copy src into dst up to and including its first zero byte
    function automatic name_t cstr_copy(input name_t dst, input name_t src);
        name_t res;
        logic  hit_zero;
        res      = dst;
        hit_zero = 1'b0;
        for (int k = 0; k < NAME_LEN; k++)
        begin
            if (!hit_zero)
            begin
                res[k] = src[k];
                if (src[k] == '0)
                    hit_zero = 1'b1;
            end
        end
        return res;
    endfunction

    // character 0 lands in the top byte
    function automatic logic [NAME_W-1:0] pack_name(input name_t n);
        logic [NAME_W-1:0] w;
        w = '0;
        for (int k = 0; k < NAME_LEN; k++)
            w[NAME_W-1-k*CHAR_W -: CHAR_W] = n[k];
        return w;
    endfunction

endpackage

// ----- rtl/rsna_channels.sv -----
// ----------------------------------------------------------------------------
// rsna channels
// Valid/ready channel interfaces for polls, results and configuration.
// ----------------------------------------------------------------------------
interface rsna_poll_if;
    logic                        valid;
    logic                        ready;
    logic                        rds_ready;
    logic [rsna_pkg::BLOCK_W-1:0] block_a;
    logic [rsna_pkg::BLOCK_W-1:0] block_b;
    logic [rsna_pkg::BLOCK_W-1:0] block_d;

    modport source (output valid, rds_ready, block_a, block_b, block_d, input ready);
    modport sink   (input valid, rds_ready, block_a, block_b, block_d, output ready);
endinterface

interface rsna_result_if;
    logic                        valid;
    logic                        ready;
    logic                        name_valid;
    logic [rsna_pkg::NAME_W-1:0] station_name;
    logic                        name_changed;

    modport source (output valid, name_valid, station_name, name_changed, input ready);
    modport sink   (input valid, name_valid, station_name, name_changed, output ready);
endinterface

interface rsna_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rsna_pkg::MIN_CHARS_W-1:0] min_name_chars;

    modport source (output valid, min_name_chars, input ready);
    modport sink   (input valid, min_name_chars, output ready);
endinterface

// ----- rtl/rds_station_name_assembler_core.sv -----
// ----------------------------------------------------------------------------
// rds_station_name_assembler_core
// Builds the eight-character program service name from polled RDS groups.
// ----------------------------------------------------------------------------
// usage:
//   poll   : one transaction per RDS poll (rds_ready, blocks A, B and D)
//   result : one transaction per poll, in order, with the published name,
//            its valid flag and a flag that this poll published a new name
//   cfg    : writes min_name_chars; always ready, write only while idle
// timing:
//   a poll lands in an input register, the name update runs combinationally
//   from it into the result register, so a poll reaches the result
//   transaction through the input register and then the result register
//   one poll per cycle is sustained while result.ready stays high, set by the
//   single register-to-register update of the name stores
// reset:
//   all name stores and the valid flag clear, min_name_chars returns to 4,
//   both pipeline registers empty
// stalls:
//   while result.ready is low the result register holds, the input register
//   fills, and poll.ready drops once both are occupied
// ----------------------------------------------------------------------------
module rds_station_name_assembler_core (
    input logic          clk,
    input logic          rst_n,
    rsna_poll_if.sink    poll,
    rsna_result_if.source result,
    rsna_cfg_if.sink     cfg
);
    import rsna_pkg::*;

    logic                   in_valid_reg;
    logic                   in_valid_next;
    poll_t                  in_data_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    result_t                out_data_reg;
    result_t                engine_result;
    logic [MIN_CHARS_W-1:0] min_chars_reg;
    logic                   out_free;
    logic                   advance;
    logic                   take;

    assign out_free  = !out_valid_reg || result.ready;
    assign advance   = in_valid_reg && out_free;
    assign poll.ready = !in_valid_reg || advance;
    assign take      = poll.valid && poll.ready;
    assign cfg.ready = 1'b1;

    assign in_valid_next  = take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    rsna_name_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .item           (in_data_reg),
        .min_name_chars (min_chars_reg),
        .result         (engine_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            min_chars_reg <= MIN_CHARS_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
                min_chars_reg <= cfg.min_name_chars;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg.rds_ready <= poll.rds_ready;
            in_data_reg.block_a   <= poll.block_a;
            in_data_reg.block_b   <= poll.block_b;
            in_data_reg.block_d   <= poll.block_d;
        end
        if (advance)
            out_data_reg <= engine_result;
    end

    assign result.valid        = out_valid_reg;
    assign result.name_valid   = out_data_reg.name_valid;
    assign result.station_name = out_data_reg.station_name;
    assign result.name_changed = out_data_reg.name_changed;

    // a newly published name always comes with the valid flag
    a_changed_implies_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_data_reg.name_changed || out_data_reg.name_valid))
        else $error("name_changed without name_valid");

    // a processed poll always leaves a result behind
    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed poll produced no result");

    // a held poll is not dropped while the output is blocked
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("pending poll lost during stall");

    // a blocked result register keeps its contents
    a_output_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("result overwritten during stall");

endmodule

// ----- rtl/rsna_name_engine.sv -----
// ----------------------------------------------------------------------------
// rsna_name_engine
// Name stores and the combinational update for one registered poll.
// ----------------------------------------------------------------------------
module rsna_name_engine (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  rsna_pkg::poll_t                  item,
    input  logic [rsna_pkg::MIN_CHARS_W-1:0] min_name_chars,
    output rsna_pkg::result_t                result
);
    import rsna_pkg::*;

    name_t first_reg;
    name_t first_next;
    name_t confirm_reg;
    name_t confirm_next;
    name_t pub_reg;
    name_t pub_next;
    logic  flag_reg;
    logic  flag_next;
    logic  changed;

    logic [1:0]             seg;
    logic [2:0]             idx_hi;
    logic [2:0]             idx_lo;
    char_t                  c1;
    char_t                  c2;
    logic                   same;
    logic [MIN_CHARS_W-1:0] need;
    logic                   prefix_ok;

    assign seg    = item.block_b[1:0];
    assign idx_hi = {seg, 1'b0};
    assign idx_lo = {seg, 1'b1};
    assign c1     = item.block_d[BLOCK_W-1 -: CHAR_W];
    assign c2     = item.block_d[CHAR_W-1:0];
    assign same   = (first_reg[idx_hi] == c1) && (first_reg[idx_lo] == c2);
    assign need   = (min_name_chars > MIN_CHARS_MAX) ? MIN_CHARS_MAX : min_name_chars;

    always_comb
    begin
        first_next   = first_reg;
        confirm_next = confirm_reg;
        pub_next     = pub_reg;
        flag_next    = flag_reg;
        changed      = 1'b0;
        prefix_ok    = 1'b1;

        if (step && item.rds_ready)
        begin
            if (item.block_a == BLOCK_A_CLEAR)
            begin
                first_next   = '0;
                confirm_next = '0;
                pub_next     = '0;
                flag_next    = 1'b0;
            end
            else if ((item.block_b & GROUP_TYPE_MASK) == '0)
            begin
                if (same)
                begin
                    confirm_next[idx_hi] = c1;
                    confirm_next[idx_lo] = c2;
                    for (int k = 0; k < NAME_LEN; k++)
                    begin
                        if ((MIN_CHARS_W'(k) < need) && (confirm_next[k] == '0))
                            prefix_ok = 1'b0;
                    end
                    // publish only a fully confirmed, long enough, different name
                    if ((seg == LAST_SEGMENT) && cstr_equal(first_reg, confirm_next) &&
                        prefix_ok && !cstr_equal(confirm_next, pub_reg))
                    begin
                        pub_next  = cstr_copy(pub_reg, confirm_next);
                        flag_next = 1'b1;
                        changed   = 1'b1;
                    end
                end
                else
                begin
                    first_next[idx_hi] = c1;
                    first_next[idx_lo] = c2;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg   <= '0;
            confirm_reg <= '0;
            pub_reg     <= '0;
            flag_reg    <= 1'b0;
        end
        else
        begin
            first_reg   <= first_next;
            confirm_reg <= confirm_next;
            pub_reg     <= pub_next;
            flag_reg    <= flag_next;
        end
    end

    assign result.name_valid   = flag_next;
    assign result.station_name = pack_name(pub_next);
    assign result.name_changed = changed;

endmodule
